/* hdl/bec_pkg.sv */
// shared types and constants for the button event classifier
`default_nettype none
package bec_pkg;

  localparam int NUM_BUTTONS = 16;
  localparam int COUNT_WIDTH = 16;
  localparam int PHASE_WIDTH = 16;
  localparam int CFG_WIDTH   = 16;
  localparam int ID_WIDTH    = 4;
  localparam int IDX_WIDTH   = $clog2(NUM_BUTTONS);

  // configuration register indexes
  localparam logic [1:0] CFG_REPEAT_THRESHOLD = 2'd0;
  localparam logic [1:0] CFG_REPEAT_PERIOD    = 2'd1;
  localparam logic [1:0] CFG_LONG_THRESHOLD   = 2'd2;

  localparam logic [CFG_WIDTH-1:0] RST_REPEAT_THRESHOLD = CFG_WIDTH'(50);
  localparam logic [CFG_WIDTH-1:0] RST_REPEAT_PERIOD    = CFG_WIDTH'(10);
  localparam logic [CFG_WIDTH-1:0] RST_LONG_THRESHOLD   = CFG_WIDTH'(100);

  // instant event codes
  localparam logic [1:0] EV_NONE    = 2'd0;
  localparam logic [1:0] EV_PRESS   = 2'd1;
  localparam logic [1:0] EV_RELEASE = 2'd2;

  // hold event codes
  localparam logic [1:0] HOLD_NONE  = 2'd0;
  localparam logic [1:0] HOLD_SHORT = 2'd1;
  localparam logic [1:0] HOLD_LONG  = 2'd2;

  typedef struct packed {
    logic [ID_WIDTH-1:0] button_id;
    logic                pin_level;
  } in_item_t;

  typedef struct packed {
    logic [1:0] instant_event;
    logic [1:0] hold_event;
  } out_item_t;

  typedef struct packed {
    logic                   previous_level;
    logic [COUNT_WIDTH-1:0] held_ticks;
    logic [PHASE_WIDTH-1:0] repeat_phase;
  } btn_state_t;

  typedef struct packed {
    logic [CFG_WIDTH-1:0] repeat_threshold;
    logic [CFG_WIDTH-1:0] repeat_period;
    logic [CFG_WIDTH-1:0] long_press_threshold;
  } cfg_regs_t;

  localparam btn_state_t BTN_STATE_RST = '{
    previous_level: 1'b1,
    held_ticks:     '0,
    repeat_phase:   '0
  };

endpackage
`default_nettype wire

/* hdl/bec_update.sv */
// per-button next state and event decode for one sample
`default_nettype none
module bec_update (
  input  wire  bec_pkg::btn_state_t cur_state,
  input  wire  bec_pkg::cfg_regs_t  cfg,
  input  wire                       pin_level,
  output bec_pkg::btn_state_t       nxt_state,
  output bec_pkg::out_item_t        result
);

  localparam logic [bec_pkg::COUNT_WIDTH-1:0] COUNT_MAX = '1;

  logic                           not_sat;
  logic [bec_pkg::COUNT_WIDTH-1:0] held_inc;
  logic [bec_pkg::PHASE_WIDTH:0]   phase_inc;
  logic [bec_pkg::CFG_WIDTH:0]     long_mark;
  logic                           phase_wrap;

  always_comb begin
    not_sat    = cur_state.held_ticks != COUNT_MAX;
    held_inc   = not_sat ? cur_state.held_ticks + 1'b1 : cur_state.held_ticks;
    phase_inc  = {1'b0, cur_state.repeat_phase} + 1'b1;
    long_mark  = {1'b0, cfg.long_press_threshold} + 1'b1;
    phase_wrap = phase_inc >= {1'b0, cfg.repeat_period};

    nxt_state.previous_level = pin_level;
    nxt_state.held_ticks     = '0;
    nxt_state.repeat_phase   = '0;
    result.instant_event     = bec_pkg::EV_NONE;
    result.hold_event        = bec_pkg::HOLD_NONE;

    if (pin_level == cur_state.previous_level) begin
      if (!pin_level) begin
        nxt_state.held_ticks = held_inc;
        if (not_sat && ({1'b0, held_inc} == long_mark)) begin
          result.hold_event = bec_pkg::HOLD_LONG;
        end
        if (phase_wrap) begin
          if (held_inc > cfg.repeat_threshold) begin
            result.instant_event = bec_pkg::EV_PRESS;
          end
        end else begin
          nxt_state.repeat_phase = phase_inc[bec_pkg::PHASE_WIDTH-1:0];
        end
      end
    end else begin
      result.instant_event = pin_level ? bec_pkg::EV_RELEASE : bec_pkg::EV_PRESS;
      if ((cur_state.held_ticks != '0) &&
          (cur_state.held_ticks < cfg.long_press_threshold)) begin
        result.hold_event = bec_pkg::HOLD_SHORT;
      end
    end
  end

endmodule
`default_nettype wire

/* hdl/button_event_classifier.sv */
// pipeline: a taken sample is registered into stage 1 with its table read, and its
//   result is registered into the output register when stage 1 advances
// throughput: one sample per cycle unless the output stalls; stage 1 reads its
//   table entry and writes it back, the last write forwarded to the next reader
// reset: synchronous; per-entry valid bits clear at once so every button reads
//   as released with zero counts, registers return to 50, 10 and 100
`default_nettype none
module button_event_classifier (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     in_valid,
  output logic                    in_ready,
  input  wire  bec_pkg::in_item_t in_data,
  output logic                    out_valid,
  input  wire                     out_ready,
  output bec_pkg::out_item_t      out_data,
  input  wire                     cfg_valid,
  output logic                    cfg_ready,
  input  wire  [1:0]              cfg_index,
  input  wire  [bec_pkg::CFG_WIDTH-1:0] cfg_data
);

  bec_pkg::cfg_regs_t cfg_r;

  bec_pkg::btn_state_t mem [bec_pkg::NUM_BUTTONS];
  logic [bec_pkg::NUM_BUTTONS-1:0] ent_vld_r;

  logic                          in_fire;
  logic [bec_pkg::IDX_WIDTH-1:0] in_idx;

  // stage 1: table data back, update computed
  logic                          s1_vld_r;
  logic                          s1_in_range_r;
  logic [bec_pkg::IDX_WIDTH-1:0] s1_idx_r;
  logic                          s1_level_r;
  logic                          s1_ent_vld_r;
  bec_pkg::btn_state_t           s1_rdata_r;
  logic                          s1_adv;

  // last written entry, covers a read taken at the same edge as the write
  logic                          fwd_vld_r;
  logic [bec_pkg::IDX_WIDTH-1:0] fwd_idx_r;
  bec_pkg::btn_state_t           fwd_data_r;

  bec_pkg::btn_state_t cur_state;
  bec_pkg::btn_state_t nxt_state;
  bec_pkg::out_item_t  upd_result;
  logic                wr_en;

  logic               out_vld_r;
  bec_pkg::out_item_t out_data_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.repeat_threshold     <= bec_pkg::RST_REPEAT_THRESHOLD;
      cfg_r.repeat_period        <= bec_pkg::RST_REPEAT_PERIOD;
      cfg_r.long_press_threshold <= bec_pkg::RST_LONG_THRESHOLD;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        bec_pkg::CFG_REPEAT_THRESHOLD: cfg_r.repeat_threshold     <= cfg_data;
        bec_pkg::CFG_REPEAT_PERIOD:    cfg_r.repeat_period        <= cfg_data;
        bec_pkg::CFG_LONG_THRESHOLD:   cfg_r.long_press_threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  assign s1_adv   = s1_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !s1_vld_r || s1_adv;
  assign in_fire  = in_valid && in_ready;
  assign in_idx   = in_data.button_id[bec_pkg::IDX_WIDTH-1:0];

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_rdata_r    <= mem[in_idx];
      s1_ent_vld_r  <= ent_vld_r[in_idx];
      s1_idx_r      <= in_idx;
      s1_level_r    <= in_data.pin_level;
      s1_in_range_r <= 32'(in_data.button_id) < bec_pkg::NUM_BUTTONS;
    end
    if (wr_en) begin
      mem[s1_idx_r] <= nxt_state;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      ent_vld_r <= '0;
      fwd_vld_r <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_vld_r <= 1'b1;
      end else if (s1_adv) begin
        s1_vld_r <= 1'b0;
      end
      if (wr_en) begin
        ent_vld_r[s1_idx_r] <= 1'b1;
        fwd_vld_r           <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      fwd_idx_r  <= s1_idx_r;
      fwd_data_r <= nxt_state;
    end
  end

  always_comb begin
    if (fwd_vld_r && (fwd_idx_r == s1_idx_r)) begin
      cur_state = fwd_data_r;
    end else if (s1_ent_vld_r) begin
      cur_state = s1_rdata_r;
    end else begin
      cur_state = bec_pkg::BTN_STATE_RST;
    end
  end

  bec_update u_update (
    .cur_state (cur_state),
    .cfg       (cfg_r),
    .pin_level (s1_level_r),
    .nxt_state (nxt_state),
    .result    (upd_result)
  );

  assign wr_en = s1_adv && s1_in_range_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (s1_adv) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      if (s1_in_range_r) begin
        out_data_r <= upd_result;
      end else begin
        out_data_r.instant_event <= bec_pkg::EV_NONE;
        out_data_r.hold_event    <= bec_pkg::HOLD_NONE;
      end
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire
